/* rtl/core/deq_pkg.sv */
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared widths, operation and status codes, and the cell command type.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int DATA_W       = 32;
	localparam int MODE_W       = 3;
	localparam int STATUS_W     = 2;
	localparam int CAPACITY_DEF = 16;

	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_LIST       = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	// Command broadcast to every cell of the chain in the same cycle.
	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_PUSH_FRONT,
		CMD_PUSH_BACK,
		CMD_POP_FRONT,
		CMD_POP_BACK,
		CMD_ROTATE
	} cell_cmd_t;

endpackage

/* rtl/core/deq_in_if.sv */
// ----------------------------------------------------------------------------
// Double-ended queue request channel
// Valid/ready channel that carries one operation word.
// ----------------------------------------------------------------------------
interface deq_in_if;

	logic                                 valid;
	logic                                 ready;
	logic        [deq_pkg::MODE_W-1:0]    mode;
	logic signed [deq_pkg::DATA_W-1:0]    push_value;

	modport source (output valid, output mode, output push_value, input ready);
	modport sink   (input valid, input mode, input push_value, output ready);

endinterface

/* rtl/core/deq_out_if.sv */
// ----------------------------------------------------------------------------
// Double-ended queue response channel
// Valid/ready channel that carries one result word.
// ----------------------------------------------------------------------------
interface deq_out_if;

	logic                                 valid;
	logic                                 ready;
	logic signed [deq_pkg::DATA_W-1:0]    result_value;
	logic        [deq_pkg::STATUS_W-1:0]  status;
	logic                                 last_result;

	modport source (output valid, output result_value, output status,
		output last_result, input ready);
	modport sink   (input valid, input result_value, input status,
		input last_result, output ready);

endinterface

/* rtl/core/deq_cell.sv */
// ----------------------------------------------------------------------------
// Double-ended queue cell
// Holds one entry and its occupancy; moves data to and from its neighbors.
// ----------------------------------------------------------------------------
module deq_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  deq_pkg::cell_cmd_t                cmd,
	input  logic signed [deq_pkg::DATA_W-1:0] push_value,
	input  logic signed [deq_pkg::DATA_W-1:0] head_data,
	input  logic signed [deq_pkg::DATA_W-1:0] prev_data,
	input  logic                              prev_occ,
	input  logic signed [deq_pkg::DATA_W-1:0] next_data,
	input  logic                              next_occ,
	output logic signed [deq_pkg::DATA_W-1:0] data,
	output logic                              occ,
	output logic signed [deq_pkg::DATA_W-1:0] tail_data
);

	logic signed [deq_pkg::DATA_W-1:0] data_q;
	logic signed [deq_pkg::DATA_W-1:0] data_d;
	logic                              occ_q;
	logic                              occ_d;

	always_comb begin
		data_d = data_q;
		occ_d  = occ_q;
		unique case (cmd)
			deq_pkg::CMD_PUSH_FRONT: begin
				data_d = prev_data;
				occ_d  = prev_occ;
			end
			deq_pkg::CMD_PUSH_BACK: begin
				if (!occ_q && prev_occ) begin
					data_d = push_value;
					occ_d  = 1'b1;
				end
			end
			deq_pkg::CMD_POP_FRONT: begin
				data_d = next_data;
				occ_d  = next_occ;
			end
			deq_pkg::CMD_POP_BACK: begin
				if (occ_q && !next_occ) begin
					occ_d = 1'b0;
				end
			end
			deq_pkg::CMD_ROTATE: begin
				// The back cell wraps the front entry around to itself.
				if (next_occ) begin
					data_d = next_data;
				end else if (occ_q) begin
					data_d = head_data;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			occ_q <= occ_d;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data      = data_q;
	assign occ       = occ_q;
	assign tail_data = (occ_q && !next_occ) ? data_q : '0;

endmodule

/* rtl/core/double_ended_queue.sv */
// Push and pop: the result word is registered when the request is accepted,
// and a new request is taken every cycle while results are taken.
// List: one result word per cycle for each stored entry while results are
// taken, as the cell chain rotates once; an empty queue gives one EMPTY word.
// Reset clears the occupancy of every cell: the queue starts empty.
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque held in a chain of cells, front entry in the first cell.
// ----------------------------------------------------------------------------
module double_ended_queue #(
	parameter int CAPACITY = deq_pkg::CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	deq_in_if.sink    req,
	deq_out_if.source rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_LIST = 2'b10
	} state_t;

	state_t                            state_q;
	logic [CNT_W-1:0]                  cnt_q;
	logic [CNT_W-1:0]                  list_left_q;
	logic                              out_valid_q;
	logic signed [deq_pkg::DATA_W-1:0] out_value_q;
	logic [deq_pkg::STATUS_W-1:0]      out_status_q;
	logic                              out_last_q;

	deq_pkg::cell_cmd_t                cmd;
	logic signed [deq_pkg::DATA_W-1:0] cell_data [CAPACITY];
	logic signed [deq_pkg::DATA_W-1:0] cell_tail [CAPACITY];
	logic [CAPACITY-1:0]               cell_occ;
	logic signed [deq_pkg::DATA_W-1:0] back_value;

	logic slot_free;
	logic accept;
	logic full;
	logic empty;
	logic word_load;

	assign slot_free = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && slot_free;
	assign accept    = req.valid && req.ready;
	assign full      = cell_occ[CAPACITY-1];
	assign empty     = !cell_occ[0];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [deq_pkg::DATA_W-1:0] prev_data;
		logic                              prev_occ;
		logic signed [deq_pkg::DATA_W-1:0] next_data;
		logic                              next_occ;

		if (i == 0) begin : g_first
			assign prev_data = req.push_value;
			assign prev_occ  = 1'b1;
		end else begin : g_inner_prev
			assign prev_data = cell_data[i-1];
			assign prev_occ  = cell_occ[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign next_data = '0;
			assign next_occ  = 1'b0;
		end else begin : g_inner_next
			assign next_data = cell_data[i+1];
			assign next_occ  = cell_occ[i+1];
		end

		deq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.push_value (req.push_value),
			.head_data  (cell_data[0]),
			.prev_data  (prev_data),
			.prev_occ   (prev_occ),
			.next_data  (next_data),
			.next_occ   (next_occ),
			.data       (cell_data[i]),
			.occ        (cell_occ[i]),
			.tail_data  (cell_tail[i])
		);
	end

	// Only the back cell drives a nonzero tail value.
	always_comb begin
		back_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			back_value = back_value | cell_tail[i];
		end
	end

	always_comb begin
		cmd = deq_pkg::CMD_HOLD;
		if (accept) begin
			unique case (req.mode)
				deq_pkg::MODE_PUSH_FRONT: if (!full)  cmd = deq_pkg::CMD_PUSH_FRONT;
				deq_pkg::MODE_PUSH_BACK:  if (!full)  cmd = deq_pkg::CMD_PUSH_BACK;
				deq_pkg::MODE_POP_FRONT:  if (!empty) cmd = deq_pkg::CMD_POP_FRONT;
				deq_pkg::MODE_POP_BACK:   if (!empty) cmd = deq_pkg::CMD_POP_BACK;
				default: begin
				end
			endcase
		end else if (state_q == S_LIST && slot_free) begin
			cmd = deq_pkg::CMD_ROTATE;
		end
	end

	// A new result word enters the output register in this cycle.
	always_comb begin
		word_load = 1'b0;
		if (accept) begin
			unique case (req.mode)
				deq_pkg::MODE_PUSH_FRONT, deq_pkg::MODE_PUSH_BACK,
				deq_pkg::MODE_POP_FRONT, deq_pkg::MODE_POP_BACK: begin
					word_load = 1'b1;
				end
				deq_pkg::MODE_LIST: begin
					word_load = empty;
				end
				default: begin
				end
			endcase
		end else if (state_q == S_LIST && slot_free) begin
			word_load = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			list_left_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= word_load || (out_valid_q && !rsp.ready);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (req.mode)
							deq_pkg::MODE_PUSH_FRONT, deq_pkg::MODE_PUSH_BACK: begin
								if (!full) begin
									cnt_q <= cnt_q + CNT_W'(1);
								end
							end
							deq_pkg::MODE_POP_FRONT, deq_pkg::MODE_POP_BACK: begin
								if (!empty) begin
									cnt_q <= cnt_q - CNT_W'(1);
								end
							end
							deq_pkg::MODE_LIST: begin
								if (!empty) begin
									list_left_q <= cnt_q;
									state_q     <= S_LIST;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_LIST: begin
					if (slot_free) begin
						list_left_q <= list_left_q - CNT_W'(1);
						if (list_left_q == CNT_W'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result payload; loaded on every accepted request, even one that produces no word, and on each list word.
	always_ff @(posedge clk) begin
		if (accept) begin
			out_last_q <= 1'b1;
			unique case (req.mode)
				deq_pkg::MODE_PUSH_FRONT, deq_pkg::MODE_PUSH_BACK: begin
					out_value_q  <= '0;
					out_status_q <= full ? deq_pkg::STATUS_FULL : deq_pkg::STATUS_OK;
				end
				deq_pkg::MODE_POP_FRONT: begin
					out_value_q  <= empty ? '0 : cell_data[0];
					out_status_q <= empty ? deq_pkg::STATUS_EMPTY : deq_pkg::STATUS_OK;
				end
				deq_pkg::MODE_POP_BACK: begin
					out_value_q  <= empty ? '0 : back_value;
					out_status_q <= empty ? deq_pkg::STATUS_EMPTY : deq_pkg::STATUS_OK;
				end
				deq_pkg::MODE_LIST: begin
					out_value_q  <= '0;
					out_status_q <= deq_pkg::STATUS_EMPTY;
				end
				default: begin
				end
			endcase
		end else if (state_q == S_LIST && slot_free) begin
			out_value_q  <= cell_data[0];
			out_status_q <= deq_pkg::STATUS_OK;
			out_last_q   <= (list_left_q == CNT_W'(1));
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.result_value = out_value_q;
	assign rsp.status       = out_status_q;
	assign rsp.last_result  = out_last_q;

endmodule
